FILE: rtl/smq_pkg.sv
// shared types and constants for the sliding maximum queue
`timescale 1ns / 1ps

package smq_pkg;

	localparam int FIELD_BITS = 16;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef struct packed {
		logic push;
		logic report_err;
		logic pop_top;
		logic pop_read;
		logic back_load;
		logic refill_step;
		logic refill_finish;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic back_zero;
		logic back_one;
		logic refill_done;
	} status_t;

endpackage

FILE: rtl/sliding_max_queue.sv
// top level of the sliding maximum queue: controller plus datapath
`timescale 1ns / 1ps
//
// fifo of unsigned values that reports the maximum of its contents after each word.
// input channel (in_valid / in_stall): op 0 pushes value, op 1 pops the oldest value.
// output channel (out_valid / out_stall): one word per input word with max_value,
// occupancy and error; error marks a push on a full queue or a pop on an empty one,
// which leave the queue untouched.
// path of an input word, from acceptance to the result being registered:
//   push, error, or pop with one value on the back stack: loaded on acceptance
//   pop with two or more values on the back stack: ram read, then result load
//   pop with an empty back stack: the front stack is moved one value per cycle
//   through its registered ram read, then the result load
// each value moves between stacks only once; result loads wait for a free output.
// the result sits in an output register; a new word is taken while it waits,
// as long as the register is free or being taken in that cycle.
// a stalled receiver holds the result and the block stops taking words once its
// next result would have nowhere to go.
// reset empties both stacks at once; ram contents are not cleared.
//
module sliding_max_queue
	import smq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [15:0]                value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [15:0]                max_value,
	output logic [$clog2(DEPTH+1)-1:0] occupancy,
	output logic                       error
);

	cmd_t    cmd;
	status_t status;

	smq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	smq_dp #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.value     (value),
		.max_value (max_value),
		.occupancy (occupancy),
		.error     (error)
	);

endmodule

FILE: rtl/smq_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module smq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/smq_ctrl.sv
// controller state machine for the sliding maximum queue
`timescale 1ns / 1ps

module smq_ctrl
	import smq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic    op,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_REFILL  = 3'b010,
		ST_BACK_RD = 3'b100
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !out_valid_q || !out_stall;
	assign accept    = (state_q == ST_IDLE) && in_valid && out_free;
	assign in_stall  = !((state_q == ST_IDLE) && out_free);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_PUSH) begin
						cmd.load_out = 1'b1;
						if (status.full) cmd.report_err = 1'b1;
						else cmd.push = 1'b1;
					end else if (status.empty) begin
						cmd.report_err = 1'b1;
						cmd.load_out   = 1'b1;
					end else if (status.back_one) begin
						cmd.pop_top  = 1'b1;
						cmd.load_out = 1'b1;
					end else if (status.back_zero) begin
						state_n = ST_REFILL;
					end else begin
						cmd.pop_read = 1'b1;
						state_n      = ST_BACK_RD;
					end
				end
			end
			ST_REFILL: begin
				if (!status.refill_done) begin
					cmd.refill_step = 1'b1;
				end else if (out_free) begin
					cmd.refill_finish = 1'b1;
					cmd.load_out      = 1'b1;
					state_n           = ST_IDLE;
				end
			end
			ST_BACK_RD: begin
				if (out_free) begin
					cmd.back_load = 1'b1;
					cmd.load_out  = 1'b1;
					state_n       = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/smq_dp.sv
// datapath: two stacks of value and running maximum, counts and result register
`timescale 1ns / 1ps

module smq_dp
	import smq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output status_t                      status,
	input  logic [FIELD_BITS-1:0]        value,
	output logic [FIELD_BITS-1:0]        max_value,
	output logic [$clog2(DEPTH+1)-1:0]   occupancy,
	output logic                         error
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int W  = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

	logic [CW-1:0] fc_q, bc_q, fc_n, bc_n, fc_m1, bc_m2, total;
	logic [W-1:0]  ft_q, bt_q, ft_n, bt_n, run_q, prev_q;
	logic          pend_q;
	logic [W-1:0]  v, push_m, ref_m, f_rval, b_rmax, mf, mb, res_max;

	logic          f_we, f_re, b_we, b_re;
	logic [AW-1:0] f_waddr, f_raddr, b_waddr, b_raddr;
	logic [2*W-1:0] f_wdata, f_rdata, b_wdata, b_rdata;

	logic [FIELD_BITS-1:0] max_q;
	logic [CW-1:0]         occ_q;
	logic                  err_q;

	assign v      = value[W-1:0];
	assign fc_m1  = fc_q - CW'(1);
	assign bc_m2  = bc_q - CW'(2);
	assign total  = CW'(fc_q + bc_q);
	assign f_rval = f_rdata[2*W-1:W];
	assign b_rmax = b_rdata[W-1:0];

	assign push_m = (fc_q != '0 && ft_q > v) ? ft_q : v;
	// first value moved starts the back stack's running maximum afresh
	assign ref_m  = (bc_q == '0 || f_rval > run_q) ? f_rval : run_q;

	assign status.full        = (total == CW'(DEPTH));
	assign status.empty       = (fc_q == '0) && (bc_q == '0);
	assign status.back_zero   = (bc_q == '0);
	assign status.back_one    = (bc_q == CW'(1));
	assign status.refill_done = (fc_q == '0) && !pend_q;

	always_comb begin
		fc_n    = fc_q;
		bc_n    = bc_q;
		ft_n    = ft_q;
		bt_n    = bt_q;
		f_we    = 1'b0;
		f_re    = 1'b0;
		b_we    = 1'b0;
		b_re    = 1'b0;
		f_waddr = fc_q[AW-1:0];
		f_wdata = {v, push_m};
		f_raddr = fc_m1[AW-1:0];
		b_waddr = bc_q[AW-1:0];
		b_wdata = {f_rval, ref_m};
		b_raddr = bc_m2[AW-1:0];
		if (cmd.push) begin
			f_we = 1'b1;
			fc_n = fc_q + CW'(1);
			ft_n = push_m;
		end
		if (cmd.pop_top) begin
			bc_n = bc_q - CW'(1);
		end
		if (cmd.pop_read) begin
			// fetch the maximum of the entry that becomes the new top
			b_re = 1'b1;
			bc_n = bc_q - CW'(1);
		end
		if (cmd.back_load) begin
			bt_n = b_rmax;
		end
		if (cmd.refill_step) begin
			if (fc_q != '0) begin
				f_re = 1'b1;
				fc_n = fc_q - CW'(1);
			end
			if (pend_q) begin
				b_we = 1'b1;
				bc_n = bc_q + CW'(1);
			end
		end
		if (cmd.refill_finish) begin
			// entry below the moved top carries the maximum held in prev_q
			bc_n = bc_q - CW'(1);
			bt_n = prev_q;
		end
	end

	assign mf      = (fc_n != '0) ? ft_n : '0;
	assign mb      = (bc_n != '0) ? bt_n : '0;
	assign res_max = (mf > mb) ? mf : mb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= '0;
			bc_q   <= '0;
			pend_q <= 1'b0;
		end else begin
			fc_q   <= fc_n;
			bc_q   <= bc_n;
			pend_q <= cmd.refill_step && (fc_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		ft_q <= ft_n;
		bt_q <= bt_n;
		if (b_we) begin
			run_q  <= ref_m;
			prev_q <= run_q;
		end
		if (cmd.load_out) begin
			max_q <= FIELD_BITS'(res_max);
			occ_q <= CW'(fc_n + bc_n);
			err_q <= cmd.report_err;
		end
	end

	assign max_value = max_q;
	assign occupancy = occ_q;
	assign error     = err_q;

	smq_ram #(
		.WIDTH (2 * W),
		.DEPTH (DEPTH)
	) u_front_ram (
		.clk     (clk),
		.wr_en   (f_we),
		.wr_addr (f_waddr),
		.wr_data (f_wdata),
		.rd_en   (f_re),
		.rd_addr (f_raddr),
		.rd_data (f_rdata)
	);

	smq_ram #(
		.WIDTH (2 * W),
		.DEPTH (DEPTH)
	) u_back_ram (
		.clk     (clk),
		.wr_en   (b_we),
		.wr_addr (b_waddr),
		.wr_data (b_wdata),
		.rd_en   (b_re),
		.rd_addr (b_raddr),
		.rd_data (b_rdata)
	);

endmodule

FILE: dv/tb_top.sv
// testbench for the sliding maximum queue: directed and random push/pop traffic with a predictor
`timescale 1ns / 1ps

module tb_top;
	import smq_pkg::*;

	localparam int QDEPTH = 16;
	localparam int OCC_BITS = $clog2(QDEPTH + 1);

	typedef struct {
		logic [15:0]         max_value;
		logic [OCC_BITS-1:0] occupancy;
		logic                error;
	} report_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                op = OP_PUSH;
	logic [15:0]         value = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [15:0]         max_value;
	logic [OCC_BITS-1:0] occupancy;
	logic                error;

	// predictor copy of the two stacks
	logic [15:0] front_vals [QDEPTH];
	logic [15:0] front_max [QDEPTH];
	logic [15:0] back_vals [QDEPTH];
	logic [15:0] back_max [QDEPTH];
	int          front_n;
	int          back_n;

	report_t pending_reports[$];

	int sender_idle_pct;
	int receiver_stall_pct;
	int mismatches;
	int words_sent;
	int reports_checked;
	int ignored_ops;
	int refills;

	sliding_max_queue #(
		.DEPTH(QDEPTH),
		.VALUE_BITS(16)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.max_value(max_value),
		.occupancy(occupancy),
		.error(error)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// applies one accepted word to the predictor and queues the report it should produce
	function automatic void predict_queue_report(input logic w_op, input logic [15:0] w_value);
		report_t     rep;
		logic [15:0] run_max;
		logic [15:0] v;
		rep.error = 1'b0;
		if (w_op == OP_PUSH) begin
			if (front_n + back_n >= QDEPTH) begin
				rep.error = 1'b1;
			end else begin
				run_max = w_value;
				if (front_n > 0 && front_max[front_n-1] > w_value)
					run_max = front_max[front_n-1];
				front_vals[front_n] = w_value;
				front_max[front_n] = run_max;
				front_n++;
			end
		end else begin
			if (front_n + back_n == 0) begin
				rep.error = 1'b1;
			end else begin
				if (back_n == 0) begin
					// reverse the front stack onto the back, oldest ends on top
					refills++;
					run_max = '0;
					while (front_n > 0) begin
						front_n--;
						v = front_vals[front_n];
						if (back_n == 0 || v > run_max)
							run_max = v;
						back_vals[back_n] = v;
						back_max[back_n] = run_max;
						back_n++;
					end
				end
				back_n--;
			end
		end
		rep.max_value = '0;
		if (front_n > 0)
			rep.max_value = front_max[front_n-1];
		if (back_n > 0 && back_max[back_n-1] > rep.max_value)
			rep.max_value = back_max[back_n-1];
		rep.occupancy = OCC_BITS'(front_n + back_n);
		if (rep.error)
			ignored_ops++;
		pending_reports.insert(pending_reports.size(), rep);
	endfunction

	// called at a rising edge; returns at the edge where the word is taken
	task automatic send_word(input logic w_op, input logic [15:0] w_value);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= w_op;
		value <= w_value;
		do @(posedge clk); while (in_stall);
		words_sent++;
		predict_queue_report(w_op, w_value);
	endtask

	// result checker and receiver stall generator
	always @(posedge clk) begin
		report_t exp_rep;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected: max %h occ %0d err %b",
					$time, max_value, occupancy, error);
			end else begin
				exp_rep = pending_reports.pop_front();
				reports_checked++;
				if (max_value !== exp_rep.max_value) begin
					mismatches++;
					$display("%0t: max_value expected %h actual %h",
						$time, exp_rep.max_value, max_value);
				end
				if (occupancy !== exp_rep.occupancy) begin
					mismatches++;
					$display("%0t: occupancy expected %0d actual %0d",
						$time, exp_rep.occupancy, occupancy);
				end
				if (error !== exp_rep.error) begin
					mismatches++;
					$display("%0t: error expected %b actual %b",
						$time, exp_rep.error, error);
				end
			end
		end
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	task automatic test_pop_on_empty();
		send_word(OP_POP, 16'h0000);
	endtask

	task automatic test_value_extremes();
		send_word(OP_PUSH, 16'hFFFF);
		send_word(OP_PUSH, 16'h0000);
		send_word(OP_POP, 16'hFFFF);
		send_word(OP_POP, 16'h1234);
		send_word(OP_POP, 16'hFFFF);
	endtask

	task automatic test_full_and_refill();
		logic [15:0] v;
		for (int i = 0; i < QDEPTH; i++) begin
			case (i)
				3: v = 16'hAAAA;
				9: v = 16'h5555;
				default: v = 16'($urandom);
			endcase
			send_word(OP_PUSH, v);
		end
		// push on a full queue
		send_word(OP_PUSH, 16'hFFFF);
		// first pop moves all sixteen words to the back stack
		send_word(OP_POP, 16'h0000);
		send_word(OP_PUSH, 16'h0001);
		send_word(OP_POP, 16'h0000);
	endtask

	function automatic logic [15:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 8)
			return 16'hFFFF;
		if (sel < 16)
			return 16'h0000;
		if (sel < 32)
			return 16'($urandom_range(7));
		return 16'($urandom);
	endfunction

	// bursts with a varying push share so the queue wanders between empty and full
	task automatic test_random_traffic(input int n_items);
		int done;
		int burst;
		int push_pct;
		done = 0;
		while (done < n_items) begin
			burst = $urandom_range(24, 1);
			case ($urandom_range(2))
				0: push_pct = 15;
				1: push_pct = 50;
				default: push_pct = 85;
			endcase
			for (int i = 0; i < burst && done < n_items; i++) begin
				if ($urandom_range(99) < push_pct)
					send_word(OP_PUSH, pick_value());
				else
					send_word(OP_POP, pick_value());
				done++;
			end
		end
	endtask

	initial begin
		front_n = 0;
		back_n = 0;
		mismatches = 0;
		words_sent = 0;
		reports_checked = 0;
		ignored_ops = 0;
		refills = 0;
		sender_idle_pct = 22;
		receiver_stall_pct = 54;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pop_on_empty();
		test_value_extremes();
		test_full_and_refill();

		test_random_traffic(640);
		sender_idle_pct = 54;
		receiver_stall_pct = 22;
		test_random_traffic(640);
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		test_random_traffic(640);
		in_valid <= 1'b0;

		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d words under three idling mixes, %0d results checked",
			words_sent, reports_checked);
		$display("%0d ignored operations, %0d back stack refills", ignored_ops, refills);
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/smq_pkg.sv
rtl/smq_ram.sv
rtl/smq_ctrl.sv
rtl/smq_dp.sv
rtl/sliding_max_queue.sv
dv/tb_top.sv
